/* hw/rtl/afea_pkg.sv */
// Shared types and constants for the audio frame energy alarm.
// No dependencies; every other RTL file of the block imports this package.
`default_nettype none

package afea_pkg;

   typedef enum logic [0:0] {
      OPC_SAMPLE = 1'b0,
      OPC_TICK   = 1'b1
   } opcode_type;

   localparam int SAMPLE_W     = 32;
   localparam int SAMPLE_SHIFT = 8;
   localparam int MAG_W        = 24;
   localparam int ENERGY_W     = 24;
   localparam int HOLDOFF_W    = 16;
   localparam int TICK_W       = 16;

   localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET   = 16'd500;
   localparam logic [ENERGY_W-1:0]  THRESHOLD_RESET = 24'd20000;
   localparam logic [TICK_W-1:0]    TICK_MAX        = '1;

   // Frame length must stay a power of two: the mean is a plain shift.
   localparam int FRAME_LEN   = 128;
   localparam int FRAME_SHIFT = $clog2(FRAME_LEN);
   localparam int FRAME_IDX_W = FRAME_SHIFT;
   localparam int FRAME_SUM_W = MAG_W + FRAME_SHIFT;

   localparam int CAL_FRAMES_DEFAULT = 20;

endpackage

`default_nettype wire

/* hw/rtl/afea_channels.sv */
// Valid/ready channel interfaces for the audio frame energy alarm.
// Depends on afea_pkg.
`default_nettype none

interface afea_req_if import afea_pkg::*; ();
   logic                       valid;
   logic                       ready;
   opcode_type                 opcode;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output opcode, output sample, input ready);
   modport sink   (input valid, input opcode, input sample, output ready);
endinterface

interface afea_rsp_if import afea_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ENERGY_W-1:0] energy;
   logic                calibrating;
   logic                above_threshold;
   logic                alarm;
   logic [ENERGY_W-1:0] threshold_now;

   modport source (output valid, output energy, output calibrating,
                   output above_threshold, output alarm, output threshold_now,
                   input ready);
   modport sink   (input valid, input energy, input calibrating,
                   input above_threshold, input alarm, input threshold_now,
                   output ready);
endinterface

interface afea_csr_if import afea_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [HOLDOFF_W-1:0] holdoff_ms;

   modport source (output valid, output holdoff_ms, input ready);
   modport sink   (input valid, input holdoff_ms, output ready);
endinterface

`default_nettype wire

/* hw/rtl/afea_cal_div.sv */
// Calibration threshold: mean of the calibration energies plus half of it.
// Divides by CAL_FRAMES through an exact reciprocal multiply. Uses afea_pkg.
`default_nettype none

module afea_cal_div
   import afea_pkg::*;
#(
   parameter int CAL_FRAMES = CAL_FRAMES_DEFAULT,
   parameter int SUM_W      = $clog2(CAL_FRAMES + 1) + MAG_W - 1
) (
   input  wire logic [SUM_W-1:0]    cal_sum,
   output      logic [ENERGY_W-1:0] threshold
);

   // floor(x / d) == (x * ceil(2^k / d)) >> k for every x below 2^SUM_W
   // when 2^k >= d * 2^SUM_W.
   localparam int              RECIP_K = SUM_W + $clog2(CAL_FRAMES);
   localparam int              RECIP_W = SUM_W + 2;
   localparam longint unsigned RECIP_M =
      ((64'd1 << RECIP_K) + 64'(CAL_FRAMES) - 64'd1) / 64'(CAL_FRAMES);
   localparam int              PROD_W  = SUM_W + RECIP_W;

   logic [PROD_W-1:0]   product;
   logic [ENERGY_W-1:0] base;

   always_comb begin
      product   = PROD_W'(cal_sum) * PROD_W'(RECIP_W'(RECIP_M));
      base      = product[RECIP_K +: ENERGY_W];
      threshold = base + (base >> 1);
   end

endmodule

`default_nettype wire

/* hw/rtl/audio_frame_energy_alarm_core.sv */
// Audio frame energy alarm, top level. Uses afea_pkg, the afea channel
// interfaces and afea_cal_div.
//
// Each request word is either an audio sample or a one-millisecond tick.
// Samples are shifted right arithmetically by 8 and their magnitudes summed;
// every FRAME_LEN (128) samples one response word carries the frame energy
// (mean magnitude). The first CAL_FRAMES frames set the threshold to 1.5x
// their mean energy; later frames above the threshold raise an alarm when at
// least holdoff_ms ticks (saturating at 65535) passed since the last alarm.
// Ticks and mid-frame samples produce no response. The block takes one
// request word per cycle while no frame result is held back: all per-word
// state updates happen in one pass out of the input register, and a frame
// result then goes through a threshold stage (the reciprocal multiply of
// the calibration mean) and the response register. Stalls on the response
// side back up only when a frame result finds both later stages full.
// holdoff_ms may be rewritten at any time the block is idle; the csr
// channel is always ready.
`default_nettype none

module audio_frame_energy_alarm_core
   import afea_pkg::*;
#(
   parameter int CAL_FRAMES = CAL_FRAMES_DEFAULT
) (
   input wire logic  clock,
   input wire logic  reset,
   afea_req_if.sink   req_chan,
   afea_rsp_if.source rsp_chan,
   afea_csr_if.sink   csr_chan
);

   localparam int CNT_W     = $clog2(CAL_FRAMES + 1);
   localparam int CAL_SUM_W = CNT_W + MAG_W - 1;

   // configuration
   logic [HOLDOFF_W-1:0] holdoff_ff;

   // input register (stage A)
   logic                       a_valid_ff;
   opcode_type                 a_opcode_ff;
   logic signed [SAMPLE_W-1:0] a_sample_ff;

   // block state
   logic [FRAME_SUM_W-1:0] frame_sum_ff, frame_sum_in;
   logic [FRAME_IDX_W-1:0] frame_index_ff, frame_index_in;
   logic [CAL_SUM_W-1:0]   cal_sum_ff, cal_sum_in;
   logic [CNT_W-1:0]       cal_seen_ff, cal_seen_in;
   logic                   cal_finished_ff, cal_finished_in;
   logic [ENERGY_W-1:0]    energy_threshold_ff;
   logic [TICK_W-1:0]      ticks_ff, ticks_in;

   // threshold stage (stage B)
   logic                 b_valid_ff;
   logic [ENERGY_W-1:0]  b_energy_ff, b_energy_in;
   logic                 b_cal_ff, b_cal_in;
   logic                 b_above_ff, b_above_in;
   logic                 b_alarm_ff, b_alarm_in;
   logic                 b_done_ff, b_done_in;
   logic [CAL_SUM_W-1:0] b_cal_sum_ff;

   // response register
   logic                rsp_valid_ff;
   logic [ENERGY_W-1:0] rsp_energy_ff;
   logic                rsp_cal_ff;
   logic                rsp_above_ff;
   logic                rsp_alarm_ff;
   logic [ENERGY_W-1:0] rsp_thr_ff, rsp_thr_in;

   // stage A datapath
   logic [SAMPLE_W-SAMPLE_SHIFT-1:0] shifted;
   logic [MAG_W-1:0]                 mag;
   logic [FRAME_SUM_W-1:0]           sum_next;
   logic [ENERGY_W-1:0]              energy;
   logic                             a_frame_end;
   logic                             a_adv, b_adv, b_free, rsp_free;
   logic [ENERGY_W-1:0]              cal_threshold;

   // ------------------------------------------------------------------
   // Handshake: advance a stage when the next one is empty or moving on.
   // ------------------------------------------------------------------
   assign rsp_free    = !rsp_valid_ff || rsp_chan.ready;
   assign b_adv       = b_valid_ff && rsp_free;
   assign b_free      = !b_valid_ff || b_adv;
   assign a_frame_end = a_valid_ff && (a_opcode_ff == OPC_SAMPLE) &&
                        (frame_index_ff == FRAME_IDX_W'(FRAME_LEN - 1));
   // Only a completed frame needs room downstream; everything else drops here.
   assign a_adv       = a_valid_ff && (!a_frame_end || b_free);

   assign req_chan.ready = !a_valid_ff || a_adv;
   assign csr_chan.ready = 1'b1;

   // ------------------------------------------------------------------
   // Stage A: magnitude, frame accumulation, tick count, calibration, alarm decision.
   // ------------------------------------------------------------------
   always_comb begin
      // Magnitude of (sample >>> 8), taken from the low 24 bits of the shift.
      shifted  = a_sample_ff[SAMPLE_W-1:SAMPLE_SHIFT];
      mag      = a_sample_ff[SAMPLE_W-1] ? (MAG_W'(0) - shifted[MAG_W-1:0])
                                         : shifted[MAG_W-1:0];
      sum_next = frame_sum_ff + FRAME_SUM_W'(mag);
      energy   = ENERGY_W'(sum_next >> FRAME_SHIFT);

      frame_sum_in    = frame_sum_ff;
      frame_index_in  = frame_index_ff;
      cal_sum_in      = cal_sum_ff;
      cal_seen_in     = cal_seen_ff;
      cal_finished_in = cal_finished_ff;
      ticks_in        = ticks_ff;
      b_energy_in     = energy;
      b_cal_in        = 1'b0;
      b_above_in      = 1'b0;
      b_alarm_in      = 1'b0;
      b_done_in       = 1'b0;

      if (a_opcode_ff == OPC_TICK) begin
         // saturating millisecond count
         if (ticks_ff != TICK_MAX) begin
            ticks_in = ticks_ff + TICK_W'(1);
         end
      end else if (!a_frame_end) begin
         frame_sum_in   = sum_next;
         frame_index_in = frame_index_ff + FRAME_IDX_W'(1);
      end else begin
         frame_sum_in   = '0;
         frame_index_in = '0;
         if (!cal_finished_ff) begin
            b_cal_in    = 1'b1;
            cal_sum_in  = cal_sum_ff + CAL_SUM_W'(energy);
            cal_seen_in = cal_seen_ff + CNT_W'(1);
            if (cal_seen_in == CNT_W'(CAL_FRAMES)) begin
               cal_finished_in = 1'b1;
               b_done_in       = 1'b1;
            end
         end else if (energy > energy_threshold_ff) begin
            b_above_in = 1'b1;
            if (ticks_ff >= holdoff_ff) begin
               b_alarm_in = 1'b1;
               ticks_in   = '0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage B: new threshold at the end of calibration.
   // ------------------------------------------------------------------
   afea_cal_div #(
      .CAL_FRAMES (CAL_FRAMES),
      .SUM_W      (CAL_SUM_W)
   ) u_cal_div (
      .cal_sum   (b_cal_sum_ff),
      .threshold (cal_threshold)
   );

   assign rsp_thr_in = b_done_ff ? cal_threshold : energy_threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         holdoff_ff          <= HOLDOFF_RESET;
         a_valid_ff          <= 1'b0;
         frame_sum_ff        <= '0;
         frame_index_ff      <= '0;
         cal_sum_ff          <= '0;
         cal_seen_ff         <= '0;
         cal_finished_ff     <= 1'b0;
         energy_threshold_ff <= THRESHOLD_RESET;
         ticks_ff            <= '0;
         b_valid_ff          <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            holdoff_ff <= csr_chan.holdoff_ms;
         end

         // input register
         if (req_chan.ready) begin
            a_valid_ff <= req_chan.valid;
         end

         // state advances with each word that leaves stage A
         if (a_adv) begin
            frame_sum_ff    <= frame_sum_in;
            frame_index_ff  <= frame_index_in;
            cal_sum_ff      <= cal_sum_in;
            cal_seen_ff     <= cal_seen_in;
            cal_finished_ff <= cal_finished_in;
            ticks_ff        <= ticks_in;
         end

         // Commit the calibrated threshold while stage B holds the last
         // calibration frame; the next frame end is a full frame away.
         if (b_valid_ff && b_done_ff) begin
            energy_threshold_ff <= cal_threshold;
         end

         if (b_free) begin
            b_valid_ff <= a_adv && a_frame_end;
         end

         if (rsp_free) begin
            rsp_valid_ff <= b_valid_ff;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         a_opcode_ff <= req_chan.opcode;
         a_sample_ff <= req_chan.sample;
      end
      if (a_adv && a_frame_end) begin
         b_energy_ff  <= b_energy_in;
         b_cal_ff     <= b_cal_in;
         b_above_ff   <= b_above_in;
         b_alarm_ff   <= b_alarm_in;
         b_done_ff    <= b_done_in;
         b_cal_sum_ff <= cal_sum_in;
      end
      if (b_adv) begin
         rsp_energy_ff <= b_energy_ff;
         rsp_cal_ff    <= b_cal_ff;
         rsp_above_ff  <= b_above_ff;
         rsp_alarm_ff  <= b_alarm_ff;
         rsp_thr_ff    <= rsp_thr_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.energy          = rsp_energy_ff;
   assign rsp_chan.calibrating     = rsp_cal_ff;
   assign rsp_chan.above_threshold = rsp_above_ff;
   assign rsp_chan.alarm           = rsp_alarm_ff;
   assign rsp_chan.threshold_now   = rsp_thr_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_frame_room: assert property (@(posedge clock) disable iff (reset)
      (a_adv && a_frame_end) |-> b_free)
      else $error("frame result left stage A while stage B was blocked");

   a_alarm_above: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && b_alarm_ff) |-> (b_above_ff && !b_cal_ff))
      else $error("alarm without an above-threshold calibrated frame");

   a_cal_sticky: assert property (@(posedge clock) disable iff (reset)
      cal_finished_ff |=> cal_finished_ff)
      else $error("calibration finished flag fell");

   a_thr_after_cal: assert property (@(posedge clock) disable iff (reset)
      !$stable(energy_threshold_ff) |-> cal_finished_ff)
      else $error("threshold changed before calibration finished");

   a_ticks_clear: assert property (@(posedge clock) disable iff (reset)
      (a_adv && a_frame_end && b_alarm_in) |=> (ticks_ff == '0) && b_valid_ff)
      else $error("alarm did not restart the holdoff count");

endmodule

`default_nettype wire

/* sim/tb_audio_frame_energy_alarm_core.sv */
// Self-checking testbench for audio_frame_energy_alarm_core: drives sample and tick words,
// predicts each frame result with a behavioral model and checks every response word.
// Depends on afea_pkg, the afea channel interfaces and the core itself.
module tb_audio_frame_energy_alarm_core;
   import afea_pkg::*;

   localparam int HALF_PERIOD     = 4;
   localparam int CAL_FRAME_COUNT = CAL_FRAMES_DEFAULT;
   localparam int SETTLE_CYCLES   = 8;        // lets the response pipeline settle
   localparam int DRAIN_LIMIT     = 20000;    // covers the long receiver hold-off
   localparam int HOLD_CYCLES     = 1500;
   localparam int LIMIT_CYCLES    = 2000000;
   localparam logic [HOLDOFF_W-1:0] EDGE_HOLDOFF = 16'd40;

   // One expected response word.
   typedef struct {
      logic [ENERGY_W-1:0] energy;
      logic                calibrating;
      logic                above_threshold;
      logic                alarm;
      logic [ENERGY_W-1:0] threshold_now;
   } frame_result_type;

   logic clock;
   logic reset;

   afea_req_if req_bus ();
   afea_rsp_if rsp_bus ();
   afea_csr_if csr_bus ();

   audio_frame_energy_alarm_core #(.CAL_FRAMES(CAL_FRAME_COUNT)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Predictor state: a private copy of everything the block remembers.
   logic [HOLDOFF_W-1:0] holdoff_setting;
   logic [31:0]          acc_magnitude;
   int unsigned          samples_in_frame;
   logic [31:0]          cal_energy_total;
   int unsigned          cal_frames_done;
   bit                   calibrated;
   logic [ENERGY_W-1:0]  alarm_level;
   logic [TICK_W-1:0]    ticks_since_raise;

   // Frame results predicted but not yet seen on the response channel.
   frame_result_type pending_frames[$];

   // Run statistics and traffic shaping.
   int unsigned frames_predicted;
   int unsigned above_count;
   int unsigned alarm_count;
   int unsigned tick_count;
   int unsigned input_stalls;
   int unsigned responses_seen;
   int unsigned mismatch_count;
   int unsigned hold_requests;
   bit          send_idle;
   bit          recv_idle;

   // Free-running clock, period 8.
   initial clock = 1'b0;
   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Fold one accepted word into the model; queue a result when a frame closes.
   function automatic void advance_energy_model(input opcode_type opc, input logic [31:0] raw);
      logic [24:0]         magnitude;
      logic [31:0]         mean;
      logic [31:0]         base;
      frame_result_type    result;
      if (opc == OPC_TICK) begin
         // saturate rather than wrap
         if (ticks_since_raise != TICK_MAX)
            ticks_since_raise++;
         tick_count++;
         return;
      end
      // arithmetic shift by 8, then magnitude of the 24-bit result
      if (raw[31])
         magnitude = 25'h100_0000 - {1'b0, raw[31:8]};
      else
         magnitude = {1'b0, raw[31:8]};
      acc_magnitude = acc_magnitude + 32'(magnitude);
      samples_in_frame++;
      if (samples_in_frame < FRAME_LEN)
         return;

      mean = acc_magnitude / FRAME_LEN;
      acc_magnitude = '0;
      samples_in_frame = 0;
      result.energy = mean[ENERGY_W-1:0];
      result.calibrating = 1'b0;
      result.above_threshold = 1'b0;
      result.alarm = 1'b0;

      if (!calibrated) begin
         // calibration frames never alarm; the last one sets the threshold to 1.5x mean
         result.calibrating = 1'b1;
         cal_energy_total = cal_energy_total + 32'(result.energy);
         cal_frames_done++;
         if (cal_frames_done >= CAL_FRAME_COUNT) begin
            base = cal_energy_total / cal_frames_done;
            base = base + (base >> 1);
            alarm_level = base[ENERGY_W-1:0];
            calibrated = 1'b1;
         end
      end else if (result.energy > alarm_level) begin
         result.above_threshold = 1'b1;
         above_count++;
         if (ticks_since_raise >= holdoff_setting) begin
            result.alarm = 1'b1;
            ticks_since_raise = '0;
            alarm_count++;
         end
      end
      result.threshold_now = alarm_level;
      frames_predicted++;
      pending_frames.push_back(result);
   endfunction

   // Print one mismatch line and count it.
   task automatic report_mismatch(input string what);
      $display("MISMATCH at response %0d: %s", responses_seen, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   // Offer one word, after a random gap when send_idle is set; hold it until the block takes it.
   task automatic send_word(input opcode_type opc, input logic [31:0] raw);
      int unsigned gap;
      gap = send_idle ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.opcode <= opc;
      req_bus.sample <= raw;
      do begin
         @(posedge clock);
         if (!req_bus.ready)
            input_stalls++;
      end while (!req_bus.ready);
      advance_energy_model(opc, raw);
      @(negedge clock);
   endtask

   // Send one full frame of samples whose magnitudes sit around level (or pure
   // noise), with ticks sprinkled in at tick_pct percent.
   task automatic send_frame(input int unsigned level, input int unsigned jitter,
                             input int unsigned tick_pct, input bit noisy);
      longint      pick;
      logic [24:0] magnitude;
      logic [24:0] shifted;
      logic [31:0] word;
      for (int i = 0; i < FRAME_LEN; i++) begin
         if ($urandom_range(0, 99) < tick_pct)
            send_word(OPC_TICK, $urandom);
         if (noisy) begin
            word = $urandom;
         end else begin
            pick = longint'(level) + longint'($urandom_range(0, 2 * jitter)) - longint'(jitter);
            if (pick < 0)
               pick = 0;
            if (pick > 64'h80_0000)
               pick = 64'h80_0000;
            magnitude = pick[24:0];
            // the largest magnitude only exists as a negative word
            if (magnitude == 25'h80_0000 || (magnitude != 0 && $urandom_range(0, 1) == 1)) begin
               shifted = 25'h100_0000 - magnitude;
               word = {shifted[23:0], 8'($urandom)};
            end else begin
               word = {1'b0, magnitude[22:0], 8'($urandom)};
            end
         end
         send_word(OPC_SAMPLE, word);
      end
   endtask

   // Drop valid, wait for every predicted frame, then let the pipeline settle.
   task automatic drain_results();
      int unsigned waited;
      req_bus.valid <= 1'b0;
      waited = 0;
      while (pending_frames.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Rewrite holdoff_ms while the block is idle.
   task automatic write_holdoff(input logic [HOLDOFF_W-1:0] value);
      drain_results();
      csr_bus.valid      <= 1'b1;
      csr_bus.holdoff_ms <= value;
      do
         @(posedge clock);
      while (!csr_bus.ready);
      holdoff_setting = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Calibration: extreme words first, then noise and moderate frames.
   task automatic test_calibration();
      repeat (FRAME_LEN) send_word(OPC_SAMPLE, 32'h8000_0000);   // largest magnitude
      repeat (FRAME_LEN) send_word(OPC_SAMPLE, 32'h7FFF_FFFF);   // largest positive
      repeat (FRAME_LEN) send_word(OPC_SAMPLE, 32'hFFFF_FFFF);   // shifts to -1
      repeat (FRAME_LEN) send_word(OPC_SAMPLE, 32'h0000_00FF);   // shifts to zero
      // tick words carry junk samples that must be ignored
      send_word(OPC_TICK, 32'h0000_0000);
      send_word(OPC_TICK, 32'hFFFF_FFFF);
      send_frame(0, 0, 3, 1'b1);
      repeat (CAL_FRAME_COUNT - 5)
         send_frame($urandom_range(50000, 150000), 20000, 3, 1'b0);
   endtask

   // Energy equal to the threshold and one above under the reset holdoff, then
   // a short holdoff with the alarm arriving exactly when the count reaches it.
   task automatic test_threshold_edges();
      int unsigned level;
      level = 32'(alarm_level);
      send_frame(level, 0, 0, 1'b0);
      send_frame(level + 1, 0, 0, 1'b0);
      write_holdoff(EDGE_HOLDOFF);
      repeat (EDGE_HOLDOFF) send_word(OPC_TICK, $urandom);
      send_frame(level + 1, 0, 0, 1'b0);
      send_frame(level + 1, 0, 0, 1'b0);
      repeat (EDGE_HOLDOFF - 1) send_word(OPC_TICK, $urandom);
      send_frame(level + 1, 0, 0, 1'b0);
      send_word(OPC_TICK, $urandom);
      send_frame(level + 1, 0, 0, 1'b0);
   endtask

   // Zero holdoff: every loud frame alarms, even with no ticks between.
   task automatic test_holdoff_zero();
      write_holdoff('0);
      repeat (2) send_frame(8388608, 0, 0, 1'b0);
      send_frame(32'(alarm_level) / 2, 32'(alarm_level) / 8, 0, 1'b0);
   endtask

   // Largest holdoff: a loud frame after a short run of ticks must not alarm.
   task automatic test_holdoff_max();
      write_holdoff(TICK_MAX);
      send_idle = 1'b0;
      repeat (64) send_word(OPC_TICK, $urandom);
      send_idle = 1'b1;
      send_frame(32'(alarm_level) + 1000, 500, 0, 1'b0);
   endtask

   // Receiver holds off for a long stretch while samples stream in back to back.
   task automatic test_backpressure();
      int unsigned lo;
      int unsigned hi;
      lo = 32'(alarm_level) / 2;
      hi = 32'(alarm_level) * 2;
      send_idle = 1'b0;
      hold_requests++;
      repeat (4)
         send_frame($urandom_range(lo, hi), 5000, 0, 1'b0);
      send_idle = 1'b1;
   endtask

   // Random frames around the threshold under several holdoff settings.
   task automatic test_random_traffic();
      logic [HOLDOFF_W-1:0] setting;
      int unsigned          thr;
      int unsigned          kind;
      int unsigned          pct;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               setting = 16'd1;
            end
            1: begin
               setting = 16'($urandom_range(2, 60));
            end
            2: begin
               setting = 16'($urandom_range(0, 65535));
            end
            default: begin
               setting = '0;
            end
         endcase
         write_holdoff(setting);
         thr = 32'(alarm_level);
         for (int f = 0; f < 2; f++) begin
            // change the idling pattern every frame; some frames run flat out
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 9);
            pct = $urandom_range(0, 30);
            if (kind <= 3)
               send_frame(thr + thr / 8 + 1 + $urandom_range(0, thr / 4), thr / 16, pct, 1'b0);
            else if (kind <= 6)
               send_frame(thr - thr / 8 - $urandom_range(0, thr / 4), thr / 16, pct, 1'b0);
            else if (kind == 7)
               send_frame(0, 0, pct, 1'b1);
            else if (kind == 8)
               send_frame(thr, 0, pct, 1'b0);
            else
               send_frame($urandom_range(0, 16), 2, pct, 1'b0);
         end
      end
      send_idle = 1'b1;
      recv_idle = 1'b1;
   endtask

   // Receiver: draw a stall after every taken word, and serve hold-off requests.
   initial begin : rsp_ready_driver
      int unsigned stall_left;
      int unsigned holds_served;
      stall_left = 0;
      holds_served = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            stall_left = recv_idle ? $urandom_range(0, 7) : 0;
         if (holds_served != hold_requests) begin
            holds_served++;
            stall_left = stall_left + HOLD_CYCLES;
         end
         @(negedge clock);
         if (stall_left != 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Compare each taken response word with the oldest predicted frame.
   always @(posedge clock) begin : rsp_checker
      frame_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         responses_seen++;
         if (pending_frames.size() == 0) begin
            report_mismatch("response word with no frame pending");
         end else begin
            want = pending_frames.pop_front();
            check_field("energy", 32'(rsp_bus.energy), 32'(want.energy));
            check_field("calibrating", 32'(rsp_bus.calibrating), 32'(want.calibrating));
            check_field("above_threshold", 32'(rsp_bus.above_threshold),
                        32'(want.above_threshold));
            check_field("alarm", 32'(rsp_bus.alarm), 32'(want.alarm));
            check_field("threshold_now", 32'(rsp_bus.threshold_now),
                        32'(want.threshold_now));
         end
      end
   end

   initial begin : stimulus
      // hold every input at a known value through reset
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.opcode = OPC_SAMPLE;
      req_bus.sample = '0;
      csr_bus.valid = 1'b0;
      csr_bus.holdoff_ms = '0;

      holdoff_setting = HOLDOFF_RESET;
      acc_magnitude = '0;
      samples_in_frame = 0;
      cal_energy_total = '0;
      cal_frames_done = 0;
      calibrated = 1'b0;
      alarm_level = THRESHOLD_RESET;
      ticks_since_raise = '0;

      frames_predicted = 0;
      above_count = 0;
      alarm_count = 0;
      tick_count = 0;
      input_stalls = 0;
      responses_seen = 0;
      mismatch_count = 0;
      hold_requests = 0;
      send_idle = 1'b1;
      recv_idle = 1'b1;

      repeat (4) @(negedge clock);
      reset = 1'b0;

      test_calibration();
      test_threshold_edges();
      test_holdoff_zero();
      test_holdoff_max();
      test_backpressure();
      test_random_traffic();
      drain_results();

      if (pending_frames.size() != 0)
         report_mismatch($sformatf("%0d predicted frames never arrived", pending_frames.size()));

      $display("covered %0d frames: %0d calibration, %0d above threshold, %0d alarms",
               frames_predicted, cal_frames_done, above_count, alarm_count);
      $display("%0d tick words, %0d input stall cycles, %0d mismatches",
               tick_count, input_stalls, mismatch_count);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Watchdog: end a hung run.
   initial begin : watchdog
      #(LIMIT_CYCLES * 2 * HALF_PERIOD);
      $display("timeout after %0d cycles", LIMIT_CYCLES);
      $display("status: fail");
      $finish;
   end

endmodule

/* audio_frame_energy_alarm_core.f */
hw/rtl/afea_pkg.sv
hw/rtl/afea_channels.sv
hw/rtl/afea_cal_div.sv
hw/rtl/audio_frame_energy_alarm_core.sv
sim/tb_audio_frame_energy_alarm_core.sv
